// ===== hw/rtl/crc_protected_flash_block_writer_core_assert.svh =====
// Assertion macros for the CRC-protected flash record writer.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef CRC_PROTECTED_FLASH_BLOCK_WRITER_CORE_ASSERT_SVH
`define CRC_PROTECTED_FLASH_BLOCK_WRITER_CORE_ASSERT_SVH

// check a property on every clock edge outside reset
`define CRCFW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check a property on every clock edge, reset included
`define CRCFW_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/crcfw_pkg.sv =====
// Shared types and constants of the CRC-protected flash record writer.
// No dependencies.
package crcfw_pkg;

	localparam int ADDR_W            = 24;
	localparam int BLOCK_BYTES_DEF   = 32;
	localparam int PADDR_W           = 3;
	localparam int PDATA_W           = 32;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h8005;
	localparam logic [7:0]  PAD_BYTE = 8'hFF;

	localparam logic REG_IDX_BASE = 1'b0;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_PAD  = 2'd1,
		KIND_CRC  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_DATA,
		ST_PAD,
		ST_CRC_HI,
		ST_CRC_LO
	} frm_state_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [17:0] block_index;
		logic        first;
		logic        last;
	} in_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] flash_addr;
		logic [7:0]        out_byte;
		kind_t             kind;
		logic              run_end;
	} out_item_t;

	typedef struct packed {
		logic busy;
		logic closing;
	} frm_status_t;

endpackage

// ===== hw/rtl/crcfw_crc8.sv =====
// One-byte CRC16 update, polynomial 0x8005, MSB first.
// Depends on crcfw_pkg.
module crcfw_crc8 import crcfw_pkg::*; (
	input  logic [15:0] crc_in,
	input  logic [7:0]  byte_in,
	output logic [15:0] crc_out
);

	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {byte_in, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		crc_out = c;
	end

endmodule

// ===== hw/rtl/crcfw_framer.sv =====
// Record sequencer: running CRC, fill count and address, one result per advance.
// Depends on crcfw_pkg and crcfw_crc8.
module crcfw_framer import crcfw_pkg::*; #(
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [ADDR_W-1:0] base_addr,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_data,
	output logic              res_valid,
	input  logic              res_ready,
	output out_item_t         res,
	output frm_status_t       status
);

	localparam int FILL_W = $clog2(BLOCK_BYTES + 1);
	localparam logic [ADDR_W-1:0] REC_LEN  = ADDR_W'(BLOCK_BYTES + 2);
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(BLOCK_BYTES);

	frm_state_t        state_q, state_d;
	logic [15:0]       crc_q, crc_d, crc_src, crc_step;
	logic [FILL_W-1:0] fill_q, fill_d, fill_base, fill_inc;
	logic [ADDR_W-1:0] addr_q, start_addr;
	logic [7:0]        byte_src;
	logic              restart, full, advance;

	assign restart    = (state_q == ST_DATA) && in_data.first;
	assign fill_base  = restart ? '0 : fill_q;
	assign fill_inc   = fill_base + FILL_W'(1);
	assign full       = (fill_inc == FILL_MAX);
	assign start_addr = base_addr + ADDR_W'(in_data.block_index) * REC_LEN;
	assign advance    = res_valid && res_ready;

	crcfw_crc8 u_crc8 (
		.crc_in  (crc_src),
		.byte_in (byte_src),
		.crc_out (crc_step)
	);

	always_comb begin
		case (state_q)
			ST_DATA: begin
				if (full) begin
					state_d = ST_CRC_HI;
				end else if (in_data.last) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_DATA;
				end
			end
			ST_PAD: begin
				state_d = full ? ST_CRC_HI : ST_PAD;
			end
			ST_CRC_HI: state_d = ST_CRC_LO;
			ST_CRC_LO: state_d = ST_DATA;
			default:   state_d = ST_DATA;
		endcase
	end

	always_comb begin
		in_ready       = 1'b0;
		res_valid      = 1'b1;
		crc_src        = crc_q;
		byte_src       = PAD_BYTE;
		crc_d          = crc_q;
		fill_d         = fill_q;
		res.flash_addr = addr_q;
		res.out_byte   = PAD_BYTE;
		res.kind       = KIND_PAD;
		res.run_end    = 1'b0;
		case (state_q)
			ST_DATA: begin
				in_ready       = res_ready;
				res_valid      = in_valid;
				crc_src        = in_data.first ? CRC_INIT : crc_q;
				byte_src       = in_data.data_byte;
				crc_d          = crc_step;
				fill_d         = fill_inc;
				res.flash_addr = in_data.first ? start_addr : addr_q;
				res.out_byte   = in_data.data_byte;
				res.kind       = KIND_DATA;
				res.run_end    = !full && !in_data.last;
			end
			ST_PAD: begin
				crc_d  = crc_step;
				fill_d = fill_inc;
			end
			ST_CRC_HI: begin
				res.out_byte = crc_q[15:8];
				res.kind     = KIND_CRC;
			end
			ST_CRC_LO: begin
				res.out_byte = crc_q[7:0];
				res.kind     = KIND_CRC;
				res.run_end  = 1'b1;
				crc_d        = CRC_INIT;
				fill_d       = '0;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	assign status.busy    = (state_q != ST_DATA);
	assign status.closing = (state_q == ST_CRC_HI) || (state_q == ST_CRC_LO);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_DATA;
			crc_q   <= CRC_INIT;
			fill_q  <= '0;
			addr_q  <= '0;
		end else if (advance) begin
			state_q <= state_d;
			crc_q   <= crc_d;
			fill_q  <= fill_d;
			addr_q  <= res.flash_addr + ADDR_W'(1);
		end
	end

endmodule

// ===== hw/rtl/crc_protected_flash_block_writer_core.sv =====
// Top level of the CRC-protected flash record writer: register port, output register.
// Depends on crcfw_pkg, crcfw_framer and the assertion macro header.
//
// Each accepted byte comes out as one or more addressed result transfers, one
// result per clock through a single output register while out_ready is high.
// A plain data byte gives one result, so bytes stream at one per clock. The
// byte that fills a record is followed by the two CRC bytes; a last byte that
// leaves a partial record is followed by padding up to BLOCK_BYTES and the CRC.
// Emitting padding and CRC holds off the next input, as does a full output
// register. A first byte restarts at base_addr + block_index * (BLOCK_BYTES + 2),
// addresses wrap at 2^24; base_addr is at byte address 0 of the register port.
module crc_protected_flash_block_writer_core import crcfw_pkg::*; #(
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  in_item_t           in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output out_item_t          out_data
);

`include "crc_protected_flash_block_writer_core_assert.svh"

	logic [ADDR_W-1:0] base_addr_q;
	logic              out_valid_q;
	out_item_t         out_data_q;
	logic              res_valid, res_ready;
	out_item_t         res;
	frm_status_t       status;
	logic              reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[PADDR_W-1] == REG_IDX_BASE);
	assign prdata  = reg_hit ? PDATA_W'(base_addr_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_addr_q <= '0;
		end else if (psel && penable && pwrite && reg_hit) begin
			base_addr_q <= pwdata[ADDR_W-1:0];
		end
	end

	crcfw_framer #(
		.BLOCK_BYTES (BLOCK_BYTES)
	) u_framer (
		.clk       (clk),
		.arst_n    (arst_n),
		.base_addr (base_addr_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.status    (status)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`CRCFW_ASSERT(a_ready_needs_slot, in_ready |-> !(out_valid && !out_ready), "input taken while output slot is full")
	`CRCFW_ASSERT(a_run_continues, (out_valid && out_ready && !out_data.run_end) |=> out_valid, "gap inside a result run")
	`CRCFW_ASSERT(a_busy_blocks_input, (status.busy || status.closing) |-> !in_ready, "input taken during padding or CRC")

endmodule
